>>> rtl/padf_pkg.sv
// types, codes and constants shared by the ping-pong audio dac feeder
`timescale 1ns / 1ps

package padf_pkg;

   // defaults for the top-level parameters
   localparam int HALF_LENGTH_DEFAULT  = 128;
   localparam int VOLUME_STEPS_DEFAULT = 20;

   // fixed field widths
   localparam int OPCODE_WIDTH  = 3;
   localparam int WORD_WIDTH    = 32;
   localparam int SAMPLE_WIDTH  = 16;
   localparam int DAC_WIDTH     = 12;
   localparam int HEADER_WIDTH  = 7;
   localparam int VOLUME_WIDTH  = 5;
   localparam int CONV_WIDTH    = 13;

   // reset values and conversion constants
   localparam logic [HEADER_WIDTH-1:0] HEADER_WORDS_RESET = 7'd54;
   localparam logic [VOLUME_WIDTH-1:0] VOLUME_RESET       = 5'd10;
   localparam logic [CONV_WIDTH-1:0]   DAC_MID            = 13'd2048;
   localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_FULL_SCALE  = 16'h7FFF;
   localparam logic [DAC_WIDTH-1:0]    DAC_MAX            = 12'hFFF;

   // result queue
   localparam int QUEUE_DEPTH = 8;

   typedef enum logic [OPCODE_WIDTH-1:0] {
      OP_LOAD_WORD   = 3'd0,
      OP_TICK        = 3'd1,
      OP_VOLUME_UP   = 3'd2,
      OP_VOLUME_DOWN = 3'd3,
      OP_TOGGLE_PLAY = 3'd4,
      OP_START_SONG  = 3'd5
   } opcode_type;

   typedef struct packed {
      logic [OPCODE_WIDTH-1:0] opcode;
      logic [WORD_WIDTH-1:0]   stereo_word;
   } req_type;

   typedef struct packed {
      logic [DAC_WIDTH-1:0] dac_code;
      logic                 refill_request;
      logic                 refill_half;
   } rsp_type;

   typedef struct packed {
      logic                    refill_request;
      logic                    refill_half;
      logic [VOLUME_WIDTH-1:0] volume;
   } tick_tag_type;

endpackage

>>> rtl/pingpong_audio_dac_feeder.sv
// ping-pong buffered audio playback feeder: sample store, converter pipeline, result queue
`timescale 1ns / 1ps

// Double-buffered playback feeder. A request carries an opcode: load word writes the low
// 16 bits (right sample) of a storage word into the half being filled, sample tick reads
// one sample from the other half and returns a volume-scaled 12-bit dac code, and the
// remaining opcodes step the volume, toggle play or start a song (which refills half 0,
// skipping header_words words, then half 1). One request is taken per clock while req_ready
// is high, as the sample store is touched once per request (one write for a load, one read
// for a tick). A tick's result passes through the store's registered read, the sample to
// code conversion and the divide by VOLUME_STEPS, with the volume multiply in front of the
// queue write. Results wait in an 8-entry queue; req_ready also drops while 8 tick results
// are in flight or unread. A paused tick is taken and gives no result. After reset the
// store is cleared to zero, one entry per cycle, so req_ready is low until all 2*HALF_LENGTH
// entries (256 at the default size) are cleared; csr_ writes are taken at any time.
module pingpong_audio_dac_feeder #(
   parameter int HALF_LENGTH  = padf_pkg::HALF_LENGTH_DEFAULT,
   parameter int VOLUME_STEPS = padf_pkg::VOLUME_STEPS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  padf_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output padf_pkg::rsp_type                   rsp_data,
   input  logic                                csr_write_enable,
   input  logic [padf_pkg::HEADER_WIDTH-1:0]   csr_write_data
);

   localparam int IDX_WIDTH   = $clog2(HALF_LENGTH);
   localparam int DEPTH       = 2 * HALF_LENGTH;
   localparam int ADDR_WIDTH  = $clog2(DEPTH);
   localparam int CMP_WIDTH   = (IDX_WIDTH > padf_pkg::HEADER_WIDTH) ?
                                IDX_WIDTH : padf_pkg::HEADER_WIDTH;
   // divide by VOLUME_STEPS as multiply by a rounded-up reciprocal, exact for 13-bit codes
   localparam int RECIP_SHIFT = padf_pkg::CONV_WIDTH + $clog2(VOLUME_STEPS);
   localparam int RECIP       = ((1 << RECIP_SHIFT) + VOLUME_STEPS - 1) / VOLUME_STEPS;
   localparam int RECIP_WIDTH = padf_pkg::CONV_WIDTH + 2;
   localparam int PROD_WIDTH  = padf_pkg::CONV_WIDTH + RECIP_WIDTH;
   localparam int SCALE_WIDTH = padf_pkg::CONV_WIDTH + padf_pkg::VOLUME_WIDTH;
   localparam int QPTR_WIDTH  = $clog2(padf_pkg::QUEUE_DEPTH);
   localparam int QCNT_WIDTH  = QPTR_WIDTH + 1;
   localparam int MAG_WIDTH   = padf_pkg::SAMPLE_WIDTH + 1;

   // sample store
   logic [padf_pkg::SAMPLE_WIDTH-1:0] store [DEPTH];
   logic [padf_pkg::SAMPLE_WIDTH-1:0] rdata_ff;
   logic                              mem_we;
   logic [ADDR_WIDTH-1:0]             mem_waddr;
   logic [padf_pkg::SAMPLE_WIDTH-1:0] mem_wdata;
   logic [ADDR_WIDTH-1:0]             read_addr;
   logic [ADDR_WIDTH-1:0]             fill_addr;

   // clearing pass after reset
   logic                  clear_ff, clear_in;
   logic [ADDR_WIDTH-1:0] clear_addr_ff, clear_addr_in;

   // playback control state
   logic                              read_half_ff, read_half_in;
   logic [IDX_WIDTH-1:0]              read_index_ff, read_index_in;
   logic                              fill_half_ff, fill_half_in;
   logic [IDX_WIDTH-1:0]              fill_index_ff, fill_index_in;
   logic                              fill_pending_ff, fill_pending_in;
   logic                              fill_second_after_ff, fill_second_after_in;
   logic                              playing_ff, playing_in;
   logic [padf_pkg::VOLUME_WIDTH-1:0] volume_ff, volume_in;
   logic [padf_pkg::HEADER_WIDTH-1:0] header_words_ff, header_words_in;
   logic                              header_skip;

   // converter pipeline
   logic                             req_accept;
   logic                             issue;
   padf_pkg::tick_tag_type           issue_tag;
   logic                             s1_valid_ff;
   padf_pkg::tick_tag_type           s1_tag_ff;
   logic                             s2_valid_ff;
   padf_pkg::tick_tag_type           s2_tag_ff;
   logic [padf_pkg::CONV_WIDTH-1:0]  conv_ff, conv_in;
   logic                             s3_valid_ff;
   padf_pkg::tick_tag_type           s3_tag_ff;
   logic [padf_pkg::CONV_WIDTH-1:0]  quot_ff, quot_in;
   logic                             sample_neg;
   logic [MAG_WIDTH-1:0]             sample_mag;
   logic [padf_pkg::CONV_WIDTH-1:0]  mag_q0;
   logic [padf_pkg::CONV_WIDTH-1:0]  mag_q;
   logic [padf_pkg::SAMPLE_WIDTH-1:0] mag_rem;
   logic [PROD_WIDTH-1:0]            recip_prod;
   logic [SCALE_WIDTH-1:0]           scaled;
   padf_pkg::rsp_type                result;

   // result queue
   padf_pkg::rsp_type       queue [padf_pkg::QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_WIDTH-1:0]   queue_count_ff, queue_count_in;
   logic [QCNT_WIDTH-1:0]   outstanding_ff, outstanding_in;
   logic                    rsp_accept;

   // handshakes; a tick reserves a queue slot when taken
   assign req_ready  = !clear_ff &&
                       (outstanding_ff < QCNT_WIDTH'(padf_pkg::QUEUE_DEPTH));
   assign req_accept = req_valid && req_ready;
   assign rsp_valid  = (queue_count_ff != '0);
   assign rsp_accept = rsp_valid && rsp_ready;
   assign rsp_data   = queue[rd_ptr_ff];

   // store addresses: half select plus index
   assign read_addr = read_half_ff ?
                      ADDR_WIDTH'(HALF_LENGTH) + ADDR_WIDTH'(read_index_ff) :
                      ADDR_WIDTH'(read_index_ff);
   assign fill_addr = fill_half_ff ?
                      ADDR_WIDTH'(HALF_LENGTH) + ADDR_WIDTH'(fill_index_ff) :
                      ADDR_WIDTH'(fill_index_ff);

   // header words of the first block after song start are dropped
   assign header_skip = fill_second_after_ff &&
                        (CMP_WIDTH'(fill_index_ff) < CMP_WIDTH'(header_words_ff));

   // config register
   assign header_words_in = csr_write_enable ? csr_write_data : header_words_ff;

   // clearing pass
   always_comb begin
      clear_in      = clear_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_ff) begin
         clear_addr_in = clear_addr_ff + 1'b1;
         if (clear_addr_ff == ADDR_WIDTH'(DEPTH - 1)) begin
            clear_in = 1'b0;
         end
      end
   end

   // request decode: control state update and store write
   always_comb begin
      read_half_in         = read_half_ff;
      read_index_in        = read_index_ff;
      fill_half_in         = fill_half_ff;
      fill_index_in        = fill_index_ff;
      fill_pending_in      = fill_pending_ff;
      fill_second_after_in = fill_second_after_ff;
      playing_in           = playing_ff;
      volume_in            = volume_ff;
      issue                = 1'b0;
      issue_tag.refill_request = 1'b0;
      issue_tag.refill_half    = read_half_ff;
      issue_tag.volume         = volume_ff;
      mem_we               = clear_ff;
      mem_waddr            = clear_addr_ff;
      mem_wdata            = '0;

      if (req_accept) begin
         case (req_data.opcode)
            padf_pkg::OP_LOAD_WORD: begin
               if (fill_pending_ff) begin
                  if (!header_skip) begin
                     mem_we    = 1'b1;
                     mem_waddr = fill_addr;
                     mem_wdata = req_data.stereo_word[padf_pkg::SAMPLE_WIDTH-1:0];
                  end
                  if (fill_index_ff == IDX_WIDTH'(HALF_LENGTH - 1)) begin
                     fill_index_in = '0;
                     if (fill_second_after_ff) begin
                        // first block done, carry on into half 1
                        fill_half_in         = 1'b1;
                        fill_second_after_in = 1'b0;
                     end else begin
                        fill_pending_in = 1'b0;
                     end
                  end else begin
                     fill_index_in = fill_index_ff + 1'b1;
                  end
               end
            end
            padf_pkg::OP_TICK: begin
               if (playing_ff) begin
                  issue = 1'b1;
                  if (read_index_ff == IDX_WIDTH'(HALF_LENGTH - 1)) begin
                     // half emptied: swap and restart the fill on it
                     read_index_in            = '0;
                     read_half_in             = ~read_half_ff;
                     fill_half_in             = read_half_ff;
                     fill_index_in            = '0;
                     fill_pending_in          = 1'b1;
                     fill_second_after_in     = 1'b0;
                     issue_tag.refill_request = 1'b1;
                  end else begin
                     read_index_in = read_index_ff + 1'b1;
                  end
               end
            end
            padf_pkg::OP_VOLUME_UP: begin
               if (volume_ff < padf_pkg::VOLUME_WIDTH'(VOLUME_STEPS)) begin
                  volume_in = volume_ff + 1'b1;
               end
            end
            padf_pkg::OP_VOLUME_DOWN: begin
               if (volume_ff != '0) begin
                  volume_in = volume_ff - 1'b1;
               end
            end
            padf_pkg::OP_TOGGLE_PLAY: begin
               playing_in = ~playing_ff;
            end
            padf_pkg::OP_START_SONG: begin
               playing_in           = 1'b1;
               fill_half_in         = 1'b0;
               fill_index_in        = '0;
               fill_pending_in      = 1'b1;
               fill_second_after_in = 1'b1;
            end
            default: begin
               // unused opcodes do nothing
            end
         endcase
      end
   end

   // sample store: one write port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= store[read_addr];
   end

   // stage 2: 2048 + trunc(s*2048/32767); 32767 = 2^15-1 so one correction step
   always_comb begin
      sample_neg = rdata_ff[padf_pkg::SAMPLE_WIDTH-1];
      sample_mag = sample_neg ?
                   (MAG_WIDTH'(1) << padf_pkg::SAMPLE_WIDTH) - MAG_WIDTH'(rdata_ff) :
                   MAG_WIDTH'(rdata_ff);
      mag_q0     = sample_mag[MAG_WIDTH-1:4];
      mag_rem    = {1'b0, sample_mag[3:0], 11'd0} + padf_pkg::SAMPLE_WIDTH'(mag_q0);
      mag_q      = (mag_rem >= padf_pkg::SAMPLE_FULL_SCALE) ? mag_q0 + 1'b1 : mag_q0;
      conv_in    = sample_neg ? padf_pkg::DAC_MID - mag_q : padf_pkg::DAC_MID + mag_q;
   end

   // stage 3: divide by volume steps
   assign recip_prod = PROD_WIDTH'(conv_ff) * PROD_WIDTH'(RECIP);
   assign quot_in    = padf_pkg::CONV_WIDTH'(recip_prod >> RECIP_SHIFT);

   // stage 4: volume scale with saturation
   assign scaled = SCALE_WIDTH'(quot_ff) * SCALE_WIDTH'(s3_tag_ff.volume);
   always_comb begin
      result.refill_request = s3_tag_ff.refill_request;
      result.refill_half    = s3_tag_ff.refill_half;
      if (scaled > SCALE_WIDTH'(padf_pkg::DAC_MAX)) begin
         result.dac_code = padf_pkg::DAC_MAX;
      end else begin
         result.dac_code = scaled[padf_pkg::DAC_WIDTH-1:0];
      end
   end

   // queue and credit counts
   always_comb begin
      queue_count_in = queue_count_ff;
      outstanding_in = outstanding_ff;
      if (s3_valid_ff && !rsp_accept) begin
         queue_count_in = queue_count_ff + 1'b1;
      end else if (!s3_valid_ff && rsp_accept) begin
         queue_count_in = queue_count_ff - 1'b1;
      end
      if (issue && !rsp_accept) begin
         outstanding_in = outstanding_ff + 1'b1;
      end else if (!issue && rsp_accept) begin
         outstanding_in = outstanding_ff - 1'b1;
      end
   end

   // pipeline payload and queue entries
   always_ff @(posedge clock) begin
      s1_tag_ff <= issue_tag;
      s2_tag_ff <= s1_tag_ff;
      conv_ff   <= conv_in;
      s3_tag_ff <= s2_tag_ff;
      quot_ff   <= quot_in;
      if (s3_valid_ff) begin
         queue[wr_ptr_ff] <= result;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff             <= 1'b1;
         clear_addr_ff        <= '0;
         read_half_ff         <= 1'b0;
         read_index_ff        <= '0;
         fill_half_ff         <= 1'b0;
         fill_index_ff        <= '0;
         fill_pending_ff      <= 1'b0;
         fill_second_after_ff <= 1'b0;
         playing_ff           <= 1'b1;
         volume_ff            <= padf_pkg::VOLUME_RESET;
         header_words_ff      <= padf_pkg::HEADER_WORDS_RESET;
         s1_valid_ff          <= 1'b0;
         s2_valid_ff          <= 1'b0;
         s3_valid_ff          <= 1'b0;
         wr_ptr_ff            <= '0;
         rd_ptr_ff            <= '0;
         queue_count_ff       <= '0;
         outstanding_ff       <= '0;
      end else begin
         clear_ff             <= clear_in;
         clear_addr_ff        <= clear_addr_in;
         read_half_ff         <= read_half_in;
         read_index_ff        <= read_index_in;
         fill_half_ff         <= fill_half_in;
         fill_index_ff        <= fill_index_in;
         fill_pending_ff      <= fill_pending_in;
         fill_second_after_ff <= fill_second_after_in;
         playing_ff           <= playing_in;
         volume_ff            <= volume_in;
         header_words_ff      <= header_words_in;
         s1_valid_ff          <= issue;
         s2_valid_ff          <= s1_valid_ff;
         s3_valid_ff          <= s2_valid_ff;
         if (s3_valid_ff) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (rsp_accept) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         queue_count_ff       <= queue_count_in;
         outstanding_ff       <= outstanding_in;
      end
   end

endmodule

>>> dv/pingpong_audio_dac_feeder_tb.sv
// self-checking testbench for the ping-pong audio dac feeder
`timescale 1ns / 1ps

module pingpong_audio_dac_feeder_tb;

   localparam int HALF_LEN    = padf_pkg::HALF_LENGTH_DEFAULT;
   localparam int VOL_STEPS   = padf_pkg::VOLUME_STEPS_DEFAULT;
   localparam int FULL_SCALE  = 32767;
   localparam int MID_CODE    = 2048;
   localparam int CODE_LIMIT  = 4095;
   // quiet cycles allowed: covers the store clearing pass after reset with a wide margin
   localparam int QUIET_LIMIT = 2000;
   // pipeline is 4 deep; settle time before a register write and at the end
   localparam int SETTLE      = 20;
   localparam int PHASES      = 4;
   localparam int PHASE_ITEMS = 282;
   localparam int VOL_BURST   = 22;
   localparam int SHOWN_ERRS  = 10;

   // opcodes the block does not decode
   localparam logic [padf_pkg::OPCODE_WIDTH-1:0] OP_SPARE_A = 3'd6;
   localparam logic [padf_pkg::OPCODE_WIDTH-1:0] OP_SPARE_B = 3'd7;

   localparam padf_pkg::rsp_type NO_CHECK = '0;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   padf_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   padf_pkg::rsp_type rsp_data;
   logic              csr_write_enable = 1'b0;
   logic [padf_pkg::HEADER_WIDTH-1:0] csr_write_data = '0;

   // 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   pingpong_audio_dac_feeder u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // ------------------------------------------------------------------
   // shadow copy of the playback state
   // ------------------------------------------------------------------
   logic [padf_pkg::SAMPLE_WIDTH-1:0] shadow_store [0:2*HALF_LEN-1];
   bit      play_half;
   int      play_pos;
   bit      load_half;
   int      load_pos;
   bit      load_active;
   bit      load_then_second;   // song start: half 0 first, then half 1
   bit      is_playing;
   int      vol;
   int      skip_words;         // header words dropped from the first block

   padf_pkg::rsp_type pending_codes [$];  // dac codes still owed by the block
   int      error_count = 0;
   bit      tx_steady = 1'b0;   // sender runs without gaps while set
   bit      rx_steady = 1'b0;   // receiver runs without stalls while set

   task automatic clear_shadow();
      foreach (shadow_store[i]) shadow_store[i] = '0;
      play_half        = 1'b0;
      play_pos         = 0;
      load_half        = 1'b0;
      load_pos         = 0;
      load_active      = 1'b0;
      load_then_second = 1'b0;
      is_playing       = 1'b1;
      vol              = padf_pkg::VOLUME_RESET;
      skip_words       = padf_pkg::HEADER_WORDS_RESET;
   endtask

   // signed sample to 12-bit code, then volume scaling with saturation
   function automatic logic [padf_pkg::DAC_WIDTH-1:0] dac_for(
         input logic [padf_pkg::SAMPLE_WIDTH-1:0] raw, input int level);
      int sample;
      int centered;
      int scaled;
      sample   = $signed(raw);
      centered = (sample * MID_CODE) / FULL_SCALE + MID_CODE;
      scaled   = (centered / VOL_STEPS) * level;
      if (scaled > CODE_LIMIT) scaled = CODE_LIMIT;
      return scaled[padf_pkg::DAC_WIDTH-1:0];
   endfunction

   // advance the shadow state by one request; emits is set when a code is due
   task automatic predict_playback(input padf_pkg::req_type item, output bit emits,
                                   output padf_pkg::rsp_type code);
      emits = 1'b0;
      code  = NO_CHECK;
      case (item.opcode)
         padf_pkg::OP_LOAD_WORD: begin
            if (load_active) begin
               // header words only advance the index
               if (!(load_then_second && load_pos < skip_words))
                  shadow_store[load_half * HALF_LEN + load_pos] = item.stereo_word[15:0];
               load_pos++;
               if (load_pos >= HALF_LEN) begin
                  load_pos = 0;
                  if (load_then_second) begin
                     load_half        = 1'b1;
                     load_then_second = 1'b0;
                  end else begin
                     load_active = 1'b0;
                  end
               end
            end
         end
         padf_pkg::OP_TICK: begin
            if (is_playing) begin
               emits               = 1'b1;
               code.dac_code       = dac_for(shadow_store[play_half * HALF_LEN + play_pos],
                                             vol);
               code.refill_request = 1'b0;
               code.refill_half    = play_half;
               play_pos++;
               if (play_pos >= HALF_LEN) begin
                  // half drained: swap, abandon any fill, refill the drained half
                  play_pos            = 0;
                  load_half           = play_half;
                  play_half           = !play_half;
                  load_pos            = 0;
                  load_active         = 1'b1;
                  load_then_second    = 1'b0;
                  code.refill_request = 1'b1;
               end
            end
         end
         padf_pkg::OP_VOLUME_UP: begin
            if (vol < VOL_STEPS) vol++;
         end
         padf_pkg::OP_VOLUME_DOWN: begin
            if (vol > 0) vol--;
         end
         padf_pkg::OP_TOGGLE_PLAY: begin
            is_playing = !is_playing;
         end
         padf_pkg::OP_START_SONG: begin
            is_playing       = 1'b1;
            load_half        = 1'b0;
            load_pos         = 0;
            load_active      = 1'b1;
            load_then_second = 1'b1;
         end
         default: ;
      endcase
   endtask

   // ------------------------------------------------------------------
   // request side: called at a falling edge, returns at a falling edge
   // ------------------------------------------------------------------
   task automatic send_request(input padf_pkg::req_type item, input bit typed,
                               input padf_pkg::rsp_type want);
      int                gap;
      bit                emits;
      padf_pkg::rsp_type code;
      if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
      gap = tx_steady ? 0 : $urandom_range(0, 3);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      // request taken at this edge
      predict_playback(item, emits, code);
      if (emits) pending_codes.push_back(typed ? want : code);
      @(negedge clock);
   endtask

   // register write while nothing is in flight
   task automatic set_header_skip(input logic [padf_pkg::HEADER_WIDTH-1:0] words);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= words;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      skip_words = words;
   endtask

   // drop valid, wait for every owed code, then let the pipeline settle
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      while (pending_codes.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic padf_pkg::req_type random_request();
      padf_pkg::req_type item;
      int                pick;
      item.stereo_word = $urandom;
      // bias the right sample toward full scale, zero and minus one now and then
      if ($urandom_range(0, 7) == 0) begin
         case ($urandom_range(0, 3))
            0: item.stereo_word[15:0] = 16'h7FFF;
            1: item.stereo_word[15:0] = 16'h8000;
            2: item.stereo_word[15:0] = 16'hFFFF;
            default: item.stereo_word[15:0] = 16'h0000;
         endcase
      end
      pick = $urandom_range(0, 99);
      if (pick < 44)      item.opcode = padf_pkg::OP_LOAD_WORD;
      else if (pick < 88) item.opcode = padf_pkg::OP_TICK;
      else if (pick < 92) item.opcode = padf_pkg::OP_VOLUME_UP;
      else if (pick < 96) item.opcode = padf_pkg::OP_VOLUME_DOWN;
      else if (pick < 98) item.opcode = padf_pkg::OP_TOGGLE_PLAY;
      else if (pick < 99) item.opcode = padf_pkg::OP_START_SONG;
      else                item.opcode = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
      return item;
   endfunction

   // ------------------------------------------------------------------
   // opening script, run with header skip 0 so loads land right away;
   // codes known by inspection are typed in, the rest come from the shadow
   // ------------------------------------------------------------------
   typedef struct packed {
      logic [padf_pkg::OPCODE_WIDTH-1:0] opcode;
      logic [padf_pkg::WORD_WIDTH-1:0]   word;
      logic                              typed;
      padf_pkg::rsp_type                 want;
   } script_row_type;

   localparam int SCRIPT_ROWS = 23;

   script_row_type opening_script [0:SCRIPT_ROWS-1] = '{
      // empty store at reset volume: midpoint 2048/20*10
      '{padf_pkg::OP_TICK,        32'h0000_0000, 1'b1, {12'd1020, 1'b0, 1'b0}},
      // load with no fill pending is dropped
      '{padf_pkg::OP_LOAD_WORD,   32'hFFFF_7FFF, 1'b0, NO_CHECK},
      '{padf_pkg::OP_TICK,        32'h0000_0000, 1'b1, {12'd1020, 1'b0, 1'b0}},
      '{padf_pkg::OP_VOLUME_UP,   32'h0000_0000, 1'b0, NO_CHECK},
      '{padf_pkg::OP_TICK,        32'hFFFF_FFFF, 1'b1, {12'd1122, 1'b0, 1'b0}},
      '{padf_pkg::OP_VOLUME_DOWN, 32'h0000_0000, 1'b0, NO_CHECK},
      // paused tick gives nothing
      '{padf_pkg::OP_TOGGLE_PLAY, 32'h0000_0000, 1'b0, NO_CHECK},
      '{padf_pkg::OP_TICK,        32'h0000_0000, 1'b0, NO_CHECK},
      '{OP_SPARE_A,               32'hFFFF_FFFF, 1'b0, NO_CHECK},
      '{OP_SPARE_B,               32'h0000_0000, 1'b0, NO_CHECK},
      '{padf_pkg::OP_TOGGLE_PLAY, 32'h0000_0000, 1'b0, NO_CHECK},
      '{padf_pkg::OP_START_SONG,  32'h0000_0000, 1'b0, NO_CHECK},
      '{padf_pkg::OP_LOAD_WORD,   32'h0000_0000, 1'b0, NO_CHECK},
      '{padf_pkg::OP_LOAD_WORD,   32'hFFFF_FFFF, 1'b0, NO_CHECK},
      '{padf_pkg::OP_LOAD_WORD,   32'h1234_8000, 1'b0, NO_CHECK},
      '{padf_pkg::OP_LOAD_WORD,   32'hAAAA_7FFF, 1'b0, NO_CHECK},
      '{padf_pkg::OP_LOAD_WORD,   32'h5555_8000, 1'b0, NO_CHECK},
      '{padf_pkg::OP_LOAD_WORD,   32'h0000_FFFF, 1'b0, NO_CHECK},
      '{padf_pkg::OP_LOAD_WORD,   32'hFFFF_0001, 1'b0, NO_CHECK},
      // read position is 3: positive full scale, then negative full scale
      '{padf_pkg::OP_TICK,        32'h0000_0000, 1'b1, {12'd2040, 1'b0, 1'b0}},
      '{padf_pkg::OP_TICK,        32'h0000_0000, 1'b1, {12'd0,    1'b0, 1'b0}},
      '{padf_pkg::OP_TICK,        32'h0000_0000, 1'b0, NO_CHECK},
      '{padf_pkg::OP_TICK,        32'h0000_0000, 1'b0, NO_CHECK}
   };

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------
   initial begin : stimulus
      padf_pkg::req_type                 item;
      logic [padf_pkg::HEADER_WIDTH-1:0] phase_skip;
      clear_shadow();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // header skip 0 is the low extreme; the block clears its store meanwhile
      set_header_skip('0);
      foreach (opening_script[r]) begin
         item.opcode      = opening_script[r].opcode;
         item.stereo_word = opening_script[r].word;
         send_request(item, opening_script[r].typed, opening_script[r].want);
      end

      // random phases, each at its own header skip; the sender pauses
      // until every owed code is back before each register write
      for (int p = 0; p < PHASES; p++) begin
         drain_and_settle();
         case (p)
            0:       phase_skip = 7'd127;
            1:       phase_skip = padf_pkg::HEADER_WORDS_RESET;
            2:       phase_skip = padf_pkg::HEADER_WIDTH'($urandom_range(1, 126));
            default: phase_skip = padf_pkg::HEADER_WIDTH'($urandom_range(0, 127));
         endcase
         set_header_skip(phase_skip);

         // each phase opens a song so the header skip comes into play
         item.opcode      = padf_pkg::OP_START_SONG;
         item.stereo_word = $urandom;
         send_request(item, 1'b0, NO_CHECK);

         // push the volume into its bound, up or down by phase
         for (int b = 0; b < VOL_BURST; b++) begin
            item.opcode      = p[0] ? padf_pkg::OP_VOLUME_UP : padf_pkg::OP_VOLUME_DOWN;
            item.stereo_word = $urandom;
            send_request(item, 1'b0, NO_CHECK);
         end

         for (int n = 0; n < PHASE_ITEMS - VOL_BURST - 1; n++)
            send_request(random_request(), 1'b0, NO_CHECK);
      end

      drain_and_settle();
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // ------------------------------------------------------------------
   // result side: random stalls, every accepted code checked in order
   // ------------------------------------------------------------------
   task automatic flag_error(input string what, input padf_pkg::rsp_type want,
                             input padf_pkg::rsp_type got);
      error_count++;
      if (error_count <= SHOWN_ERRS)
         $display({"mismatch (%s): expected code %0d refill %0b half %0b, ",
                   "got code %0d refill %0b half %0b"},
                  what, want.dac_code, want.refill_request, want.refill_half,
                  got.dac_code, got.refill_request, got.refill_half);
   endtask

   initial begin : receiver
      int                stall;
      padf_pkg::rsp_type want;
      wait (!reset);
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
         stall = rx_steady ? 0 : $urandom_range(0, 3);
         repeat (stall) begin
            rsp_ready <= 1'b0;
            @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (pending_codes.size() == 0) begin
            flag_error("no code pending", NO_CHECK, rsp_data);
         end else begin
            want = pending_codes.pop_front();
            if (rsp_data.dac_code !== want.dac_code)
               flag_error("dac_code", want, rsp_data);
            else if (rsp_data.refill_request !== want.refill_request)
               flag_error("refill_request", want, rsp_data);
            else if (rsp_data.refill_half !== want.refill_half)
               flag_error("refill_half", want, rsp_data);
         end
         @(negedge clock);
      end
   end

   // watchdog: ends the run after too many cycles with no handshake at all
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("tb: failure");
      $finish;
   end

endmodule
